// ===== rtl/plvic_pkg.sv =====
// package: constants, register map, types and helpers shared by the controller
`default_nettype none
package plvic_pkg;

    localparam int NUM_SOURCES = 32;
    localparam int SRC_W       = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
    localparam logic [31:0] SRC_MASK = 32'((64'd1 << NUM_SOURCES) - 64'd1);

    // item kinds
    localparam logic [1:0] K_LINE  = 2'd0;
    localparam logic [1:0] K_READ  = 2'd1;
    localparam logic [1:0] K_WRITE = 2'd2;

    // register word indexes
    localparam logic [9:0] W_IRQ_STAT   = 10'h000;
    localparam logic [9:0] W_FIQ_STAT   = 10'h001;
    localparam logic [9:0] W_RAW        = 10'h002;
    localparam logic [9:0] W_SELECT     = 10'h003;
    localparam logic [9:0] W_ENABLE     = 10'h004;
    localparam logic [9:0] W_EN_CLEAR   = 10'h005;
    localparam logic [9:0] W_SOFT       = 10'h006;
    localparam logic [9:0] W_SOFT_CLEAR = 10'h007;
    localparam logic [9:0] W_PROTECT    = 10'h008;
    localparam logic [9:0] W_LEVEL_MASK = 10'h009;
    localparam logic [9:0] W_DAISY      = 10'h00a;
    localparam logic [9:0] W_CUR_VECT   = 10'h3c0;
    localparam logic [4:0] W_VADDR_HI   = 5'h02;
    localparam logic [4:0] W_VCTL_HI    = 5'h04;
    localparam logic [6:0] W_ID_HI      = 7'h7f;

    localparam logic [4:0] NO_LEVEL = 5'd16;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic exec;
        logic tbl_cap;
        logic use_cnt;
        logic p1_eval;
        logic p2_eval;
        logic out_load;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic is_tbl_read;
        logic is_vec_read;
        logic cnt_last;
        logic out_free;
    } t_status;

    function automatic logic is_vaddr(input logic [9:0] w);
        is_vaddr = (w[9:5] == W_VADDR_HI) && ({1'b0, w[4:0]} < 6'(NUM_SOURCES));
    endfunction

    function automatic logic is_vctl(input logic [9:0] w);
        is_vctl = (w[9:5] == W_VCTL_HI) && ({1'b0, w[4:0]} < 6'(NUM_SOURCES));
    endfunction

    function automatic logic [7:0] id_byte(input logic [2:0] i);
        case (i)
            3'd0:    id_byte = 8'h92;
            3'd1:    id_byte = 8'h11;
            3'd2:    id_byte = 8'h04;
            3'd3:    id_byte = 8'h00;
            3'd4:    id_byte = 8'h0d;
            3'd5:    id_byte = 8'hf0;
            3'd6:    id_byte = 8'h05;
            default: id_byte = 8'hb1;
        endcase
    endfunction

endpackage
`default_nettype wire

// ===== rtl/plvic_if.sv =====
// interfaces: request channel and result channel
`default_nettype none
interface plvic_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [4:0]  line_index;
    logic        line_level;
    logic [9:0]  reg_word;
    logic [31:0] write_data;
    modport source (output valid, kind, line_index, line_level, reg_word, write_data,
                    input ready);
    modport sink (input valid, kind, line_index, line_level, reg_word, write_data,
                  output ready);
endinterface

interface plvic_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] read_data;
    logic        irq_out;
    logic        fiq_out;
    modport source (output valid, read_data, irq_out, fiq_out, input ready);
    modport sink (input valid, read_data, irq_out, fiq_out, output ready);
endinterface
`default_nettype wire

// ===== rtl/plvic_ram.sv =====
// generic simple dual-port ram with registered read
`default_nettype none
module plvic_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end
endmodule
`default_nettype wire

// ===== rtl/plvic_ctrl.sv =====
// sequencer: steps each item through decode, then a table access or the vector search where needed
`default_nettype none
module plvic_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire plvic_pkg::t_status i_status,
    output plvic_pkg::t_cmd        o_cmd
);
    import plvic_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DEC  = 3'd1;
    localparam logic [2:0] S_TBL  = 3'd2;
    localparam logic [2:0] S_P1A  = 3'd3;
    localparam logic [2:0] S_P1B  = 3'd4;
    localparam logic [2:0] S_P2A  = 3'd5;
    localparam logic [2:0] S_P2B  = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_in_ready = (r_state == S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DEC;
                end
            end
            S_DEC: begin
                o_cmd.exec = 1'b1;
                if (i_status.is_vec_read) begin
                    n_state = S_P1A;
                end else if (i_status.is_tbl_read) begin
                    n_state = S_TBL;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_TBL: begin
                o_cmd.tbl_cap = 1'b1;
                n_state       = S_OUT;
            end
            S_P1A: begin
                o_cmd.use_cnt = 1'b1;
                n_state       = S_P1B;
            end
            S_P1B: begin
                o_cmd.p1_eval = 1'b1;
                n_state       = i_status.cnt_last ? S_P2A : S_P1A;
            end
            S_P2A: begin
                o_cmd.use_cnt = 1'b1;
                n_state       = S_P2B;
            end
            S_P2B: begin
                o_cmd.p2_eval = 1'b1;
                n_state       = i_status.cnt_last ? S_OUT : S_P2A;
            end
            S_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_load_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == S_DEC))
        else $error("item taken outside idle");
    a_out_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> i_status.out_free)
        else $error("result loaded over a waiting beat");
    a_no_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (!o_cmd.load && !o_in_ready))
        else $error("beat accepted while busy");
endmodule
`default_nettype wire

// ===== rtl/plvic_dp.sv =====
// datapath: register file, vector tables, priority search and result register
`default_nettype none
module plvic_dp (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    plvic_in_if.sink                i_in,
    plvic_out_if.source             o_out,
    input  wire plvic_pkg::t_cmd    i_cmd,
    output plvic_pkg::t_status      o_status
);
    import plvic_pkg::*;

    // latched item
    logic [1:0]  r_kind;
    logic [4:0]  r_idx;
    logic        r_lvl;
    logic [9:0]  r_word;
    logic [31:0] r_wdata;

    // architectural state
    logic [31:0] r_lines, r_fast, r_enable, r_soft, r_allow, r_cur_vector, r_narrow;
    logic        r_protect;
    logic [15:0] r_lmask;
    logic [3:0]  r_daisy;
    logic [4:0]  r_cur_level;
    logic [NUM_SOURCES-1:0] r_va_vld, r_vc_vld;
    logic        r_va_qv, r_vc_qv;
    logic [SRC_W-1:0] r_cnt;
    logic [31:0] r_rdata;
    logic        r_ovalid;
    logic [31:0] r_odata;
    logic        r_oirq, r_ofiq;

    logic [31:0] pend, act, rd_simple, va_q, vc_q, va_full, vc_full;
    logic [3:0]  lvl;
    logic        is_wr, va_hit, vc_hit, va_we, vc_we;
    logic [SRC_W-1:0] wr_addr, rd_addr;

    assign pend    = r_lines | r_soft;
    assign act     = pend & r_enable;
    assign is_wr   = (r_kind == K_WRITE);
    assign va_hit  = is_vaddr(r_word);
    assign vc_hit  = is_vctl(r_word);
    assign wr_addr = r_word[SRC_W-1:0];
    assign rd_addr = i_cmd.use_cnt ? r_cnt : r_word[SRC_W-1:0];
    assign va_we   = i_cmd.exec && is_wr && va_hit;
    assign vc_we   = i_cmd.exec && is_wr && vc_hit;

    // vector tables
    plvic_ram #(.WIDTH(32), .DEPTH(NUM_SOURCES)) u_vaddr (
        .i_clk(i_clk), .i_wr_en(va_we), .i_wr_addr(wr_addr), .i_wr_data(r_wdata),
        .i_rd_addr(rd_addr), .o_rd_data(va_q)
    );
    plvic_ram #(.WIDTH(32), .DEPTH(NUM_SOURCES)) u_vctl (
        .i_clk(i_clk), .i_wr_en(vc_we), .i_wr_addr(wr_addr), .i_wr_data(r_wdata),
        .i_rd_addr(rd_addr), .o_rd_data(vc_q)
    );

    // never-written entries read as their reset values
    assign va_full = r_va_qv ? va_q : 32'd0;
    assign vc_full = r_vc_qv ? vc_q : 32'hf;
    assign lvl     = vc_full[3:0];

    // flop-held register reads
    always_comb begin
        case (r_word)
            W_IRQ_STAT:   rd_simple = act & ~r_fast;
            W_FIQ_STAT:   rd_simple = act & r_fast;
            W_RAW:        rd_simple = pend;
            W_SELECT:     rd_simple = r_fast;
            W_ENABLE:     rd_simple = r_enable;
            W_SOFT:       rd_simple = r_soft;
            W_PROTECT:    rd_simple = {31'd0, r_protect};
            W_LEVEL_MASK: rd_simple = {16'd0, r_lmask};
            W_DAISY:      rd_simple = {28'd0, r_daisy};
            default: begin
                if (r_word[9:3] == W_ID_HI) begin
                    rd_simple = {24'd0, id_byte(r_word[2:0])};
                end else begin
                    rd_simple = 32'd0;
                end
            end
        endcase
    end

    // item latch
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind  <= i_in.kind;
            r_idx   <= i_in.line_index;
            r_lvl   <= i_in.line_level;
            r_word  <= i_in.reg_word;
            r_wdata <= i_in.write_data;
        end
        r_va_qv <= r_va_vld[rd_addr];
        r_vc_qv <= r_vc_vld[rd_addr];
    end

    // state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lines      <= '0;
            r_fast       <= '0;
            r_enable     <= '0;
            r_soft       <= '0;
            r_protect    <= 1'b0;
            r_lmask      <= 16'hffff;
            r_daisy      <= 4'hf;
            r_cur_vector <= '0;
            r_cur_level  <= NO_LEVEL;
            r_allow      <= '1;
            r_va_vld     <= '0;
            r_vc_vld     <= '0;
            r_cnt        <= '0;
            r_narrow     <= '0;
            r_rdata      <= '0;
        end else begin
            if (i_cmd.exec) begin
                r_rdata  <= (r_kind == K_READ) ? rd_simple : 32'd0;
                r_cnt    <= '0;
                r_narrow <= '0;
                if (r_kind == K_LINE && ({1'b0, r_idx} < 6'(NUM_SOURCES))) begin
                    r_lines[r_idx] <= r_lvl;
                end
                if (va_we) begin
                    r_va_vld[wr_addr] <= 1'b1;
                end
                if (vc_we) begin
                    r_vc_vld[wr_addr] <= 1'b1;
                end
                if (is_wr) begin
                    case (r_word)
                        W_SELECT:     r_fast    <= r_wdata & SRC_MASK;
                        W_ENABLE:     r_enable  <= r_enable | (r_wdata & SRC_MASK);
                        W_EN_CLEAR:   r_enable  <= r_enable & ~r_wdata;
                        W_SOFT:       r_soft    <= r_soft | (r_wdata & SRC_MASK);
                        W_SOFT_CLEAR: r_soft    <= r_soft & ~r_wdata;
                        W_PROTECT:    r_protect <= r_wdata[0];
                        W_LEVEL_MASK: r_lmask   <= r_wdata[15:0];
                        W_DAISY:      r_daisy   <= r_wdata[3:0];
                        W_CUR_VECT: begin
                            r_allow     <= '1;
                            r_cur_level <= NO_LEVEL;
                        end
                        default: ;
                    endcase
                end
            end
            // table read data
            if (i_cmd.tbl_cap) begin
                r_rdata <= va_hit ? va_full : vc_full;
            end
            // first pass: lowest unmasked pending level
            if (i_cmd.p1_eval) begin
                if (r_lmask[lvl] && pend[r_cnt] && r_enable[r_cnt] && !r_fast[r_cnt]
                        && ({1'b0, lvl} < r_cur_level)) begin
                    r_cur_level  <= {1'b0, lvl};
                    r_cur_vector <= va_full;
                end
            end
            // second pass: sources allowed under the new level
            if (i_cmd.p2_eval) begin
                if (r_lmask[lvl] && ({1'b0, lvl} < r_cur_level)) begin
                    r_narrow[r_cnt] <= 1'b1;
                end
                if (o_status.cnt_last) begin
                    r_allow <= r_narrow | (32'(r_lmask[lvl] && ({1'b0, lvl} < r_cur_level))
                                           << r_cnt);
                    r_rdata <= r_cur_vector;
                end
            end
            if (i_cmd.p1_eval || i_cmd.p2_eval) begin
                r_cnt <= o_status.cnt_last ? '0 : r_cnt + 1'b1;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ovalid <= 1'b1;
        end else if (o_out.ready) begin
            r_ovalid <= 1'b0;
        end
        if (i_cmd.out_load) begin
            r_odata <= r_rdata;
            r_oirq  <= |(act & ~r_fast & r_allow);
            r_ofiq  <= |(act & r_fast);
        end
    end

    assign o_out.valid     = r_ovalid;
    assign o_out.read_data = r_odata;
    assign o_out.irq_out   = r_oirq;
    assign o_out.fiq_out   = r_ofiq;

    assign o_status.is_tbl_read = (r_kind == K_READ) && (va_hit || vc_hit);
    assign o_status.is_vec_read = (r_kind == K_READ) && (r_word == W_CUR_VECT);
    assign o_status.cnt_last    = (r_cnt == SRC_W'(NUM_SOURCES - 1));
    assign o_status.out_free    = !r_ovalid || o_out.ready;

    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur_level <= NO_LEVEL)
        else $error("current level out of range");
    a_level_falls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.p1_eval |=> r_cur_level <= $past(r_cur_level))
        else $error("search raised the current level");
    a_end_service: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && is_wr && r_word == W_CUR_VECT) |=>
            (r_cur_level == NO_LEVEL && r_allow == '1))
        else $error("end of service did not restore level");
endmodule
`default_nettype wire

// ===== rtl/priority_level_vectored_irq_controller.sv =====
// top level: vectored interrupt controller, 32 sources and 16 priority levels
// sequence: a line change or flop register access goes from decode to the result register,
//   a vector table read goes through a table capture first, and a current vector read makes
//   two passes over the table rams, address then compare for each source
// throughput: one item at a time; the next beat is taken the cycle after the result loads
// reset: synchronous, clears sequencer and architectural state, not the item latch or result data;
//   tables use per-entry valid flags, so no clearing pass is needed
`default_nettype none
module priority_level_vectored_irq_controller (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    plvic_in_if.sink    i_in,
    plvic_out_if.source o_out
);
    import plvic_pkg::*;

    t_cmd    cmd;
    t_status status;
    logic    in_ready;

    assign i_in.ready = in_ready;

    // sequencer
    plvic_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in.valid),
        .o_in_ready(in_ready), .i_status(status), .o_cmd(cmd)
    );

    // datapath
    plvic_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(i_in), .o_out(o_out),
        .i_cmd(cmd), .o_status(status)
    );
endmodule
`default_nettype wire
